### src/hrpf_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the http response packet filter
package hrpf_pkg;

    localparam int FRAME_COUNT_BITS = 16;
    localparam logic [FRAME_COUNT_BITS-1:0] INDEX_MAX = {FRAME_COUNT_BITS{1'b1}};

    localparam logic [15:0] TYPE_IPV4         = 16'h0800;
    localparam logic [15:0] TYPE_QTAG         = 16'h8100;
    localparam logic [15:0] TYPE_ADTAG        = 16'h88A8;
    localparam logic [7:0]  PROTO_TCP         = 8'd6;
    localparam logic [5:0]  L2_LEN            = 6'd14;
    localparam logic [5:0]  TAG_LEN           = 6'd4;
    localparam logic [1:0]  MAX_TAGS          = 2'd2;
    localparam logic [3:0]  MIN_HDR_WORDS     = 4'd5;
    localparam logic [7:0]  MIN_HDR_BYTES     = 8'd20;
    localparam logic [6:0]  TCP_OFFSET_BYTE   = 7'd12;
    localparam logic [31:0] HTTP_WORD         = 32'h48545450;
    localparam logic [15:0] MIN_PAYLOAD_RESET = 16'd7;

    typedef enum logic [2:0] {
        REASON_NOT_IP  = 3'd0,
        REASON_NOT_TCP = 3'd1,
        REASON_OTHER   = 3'd2,
        REASON_HTTP    = 3'd3,
        REASON_BAD_IP  = 3'd4,
        REASON_BAD_TCP = 3'd5
    } reason_t;

    typedef struct packed {
        logic       advance;
        logic [7:0] data;
        logic       last;
    } step_t;

    typedef struct packed {
        logic    drop;
        reason_t reason;
    } verdict_t;

endpackage

### src/hrpf_parser.sv
`timescale 1ns / 1ps
// per-frame header parse state and end-of-frame verdict logic
module hrpf_parser
    import hrpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  step_t       step,
    input  logic [15:0] min_payload_bytes,
    output verdict_t    verdict
);

    localparam int LEN_BITS = FRAME_COUNT_BITS + 1;

    logic [FRAME_COUNT_BITS-1:0] byte_index_reg;
    logic [FRAME_COUNT_BITS-1:0] byte_index_next;
    logic [15:0]                 ether_type_reg;
    logic [15:0]                 ether_type_next;
    logic [1:0]                  tag_count_reg;
    logic [1:0]                  tag_count_next;
    logic [5:0]                  ip_start_reg;
    logic [5:0]                  ip_start_next;
    logic [3:0]                  header_words_reg;
    logic [3:0]                  header_words_next;
    logic [7:0]                  protocol_number_reg;
    logic [7:0]                  protocol_number_next;
    logic [15:0]                 ip_total_length_reg;
    logic [15:0]                 ip_total_length_next;
    logic [3:0]                  tcp_words_reg;
    logic [3:0]                  tcp_words_next;
    logic [31:0]                 payload_head_reg;
    logic [31:0]                 payload_head_next;

    logic                        at_type_hi;
    logic                        at_type_lo;
    logic                        is_tag;
    logic                        in_ip;
    logic                        in_tcp;
    logic                        in_payload;
    logic [FRAME_COUNT_BITS-1:0] ip_rel;
    logic [6:0]                  hdr_bytes;
    logic [6:0]                  tcp_flag_at;
    logic [6:0]                  payload_start;
    logic [6:0]                  payload_end;
    logic [1:0]                  payload_pos;
    logic [4:0]                  payload_shift;
    logic [LEN_BITS-1:0]         frame_len;
    logic [7:0]                  ip_min_end;
    logic [7:0]                  tcp_min_end;
    logic [17:0]                 payload_len;
    logic                        payload_long;

    // header field capture
    always_comb
    begin
        at_type_hi = byte_index_reg ==
            {{(FRAME_COUNT_BITS-6){1'b0}}, ip_start_reg - 6'd2};
        at_type_lo = byte_index_reg ==
            {{(FRAME_COUNT_BITS-6){1'b0}}, ip_start_reg - 6'd1};

        ether_type_next = ether_type_reg;
        if (at_type_hi || at_type_lo)
        begin
            ether_type_next = {ether_type_reg[7:0], step.data};
        end

        is_tag = at_type_lo && (ether_type_next == TYPE_QTAG || ether_type_next == TYPE_ADTAG)
                 && (tag_count_reg < MAX_TAGS);
        tag_count_next = is_tag ? tag_count_reg + 2'd1 : tag_count_reg;
        ip_start_next  = is_tag ? ip_start_reg + TAG_LEN : ip_start_reg;

        in_ip  = !at_type_lo && (byte_index_reg >= {{(FRAME_COUNT_BITS-6){1'b0}}, ip_start_reg});
        ip_rel = byte_index_reg - {{(FRAME_COUNT_BITS-6){1'b0}}, ip_start_reg};

        header_words_next = header_words_reg;
        if (in_ip && ip_rel == '0)
        begin
            header_words_next = step.data[3:0];
        end

        ip_total_length_next = ip_total_length_reg;
        if (in_ip && (ip_rel == FRAME_COUNT_BITS'(2) || ip_rel == FRAME_COUNT_BITS'(3)))
        begin
            ip_total_length_next = {ip_total_length_reg[7:0], step.data};
        end

        protocol_number_next = protocol_number_reg;
        if (in_ip && ip_rel == FRAME_COUNT_BITS'(9))
        begin
            protocol_number_next = step.data;
        end

        hdr_bytes   = {1'b0, header_words_next, 2'b00};
        in_tcp      = in_ip && (header_words_next >= MIN_HDR_WORDS)
                      && (ip_rel >= {{(FRAME_COUNT_BITS-7){1'b0}}, hdr_bytes});
        tcp_flag_at = hdr_bytes + TCP_OFFSET_BYTE;

        tcp_words_next = tcp_words_reg;
        if (in_tcp && ip_rel == {{(FRAME_COUNT_BITS-7){1'b0}}, tcp_flag_at})
        begin
            tcp_words_next = step.data[7:4];
        end

        payload_start = hdr_bytes + {1'b0, tcp_words_next, 2'b00};
        payload_end   = payload_start + 7'd4;
        in_payload    = in_tcp && (tcp_words_next >= MIN_HDR_WORDS)
                        && (ip_rel >= {{(FRAME_COUNT_BITS-7){1'b0}}, payload_start})
                        && (ip_rel < {{(FRAME_COUNT_BITS-7){1'b0}}, payload_end});
        payload_pos   = ip_rel[1:0] - payload_start[1:0];
        payload_shift = {2'd3 - payload_pos, 3'b000};

        payload_head_next = payload_head_reg;
        if (in_payload)
        begin
            payload_head_next = payload_head_reg | ({24'b0, step.data} << payload_shift);
        end

        byte_index_next = (byte_index_reg < INDEX_MAX) ? byte_index_reg + 1'b1 : byte_index_reg;
    end

    // verdict on the state after this byte
    always_comb
    begin
        frame_len    = {1'b0, byte_index_reg} + LEN_BITS'(1);
        ip_min_end   = {2'b00, ip_start_next} + MIN_HDR_BYTES;
        tcp_min_end  = {2'b00, ip_start_next} + {1'b0, hdr_bytes} + MIN_HDR_BYTES;
        payload_len  = {2'b00, ip_total_length_next} - {11'b0, hdr_bytes}
                       - {12'b0, tcp_words_next, 2'b00};
        payload_long = !payload_len[17] && (payload_len[16:0] >= {1'b0, min_payload_bytes});

        verdict.drop   = 1'b0;
        verdict.reason = REASON_NOT_IP;
        if (frame_len < {{(LEN_BITS-6){1'b0}}, ip_start_next} || ether_type_next != TYPE_IPV4)
        begin
            verdict.reason = REASON_NOT_IP;
        end
        else if (frame_len < {{(LEN_BITS-8){1'b0}}, ip_min_end})
        begin
            verdict.drop   = 1'b1;
            verdict.reason = REASON_BAD_IP;
        end
        else if (protocol_number_next != PROTO_TCP)
        begin
            verdict.reason = REASON_NOT_TCP;
        end
        else if (header_words_next < MIN_HDR_WORDS)
        begin
            verdict.drop   = 1'b1;
            verdict.reason = REASON_BAD_IP;
        end
        else if (frame_len < {{(LEN_BITS-8){1'b0}}, tcp_min_end}
                 || tcp_words_next < MIN_HDR_WORDS)
        begin
            verdict.drop   = 1'b1;
            verdict.reason = REASON_BAD_TCP;
        end
        else if (payload_long && payload_head_next == HTTP_WORD)
        begin
            verdict.drop   = 1'b1;
            verdict.reason = REASON_HTTP;
        end
        else
        begin
            verdict.reason = REASON_OTHER;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg      <= '0;
            ether_type_reg      <= '0;
            tag_count_reg       <= '0;
            ip_start_reg        <= L2_LEN;
            header_words_reg    <= '0;
            protocol_number_reg <= '0;
            ip_total_length_reg <= '0;
            tcp_words_reg       <= '0;
            payload_head_reg    <= '0;
        end
        else if (step.advance)
        begin
            if (step.last)
            begin
                byte_index_reg      <= '0;
                ether_type_reg      <= '0;
                tag_count_reg       <= '0;
                ip_start_reg        <= L2_LEN;
                header_words_reg    <= '0;
                protocol_number_reg <= '0;
                ip_total_length_reg <= '0;
                tcp_words_reg       <= '0;
                payload_head_reg    <= '0;
            end
            else
            begin
                byte_index_reg      <= byte_index_next;
                ether_type_reg      <= ether_type_next;
                tag_count_reg       <= tag_count_next;
                ip_start_reg        <= ip_start_next;
                header_words_reg    <= header_words_next;
                protocol_number_reg <= protocol_number_next;
                ip_total_length_reg <= ip_total_length_next;
                tcp_words_reg       <= tcp_words_next;
                payload_head_reg    <= payload_head_next;
            end
        end
    end

endmodule

### src/http_response_packet_filter.sv
`timescale 1ns / 1ps
// Ethernet frame classifier that drops IPv4/TCP frames whose payload starts with HTTP.
// Frame bytes enter one per transfer starting at the destination MAC, with
// last_byte marking the final byte; up to two 802.1Q/802.1ad tags are skipped
// and the IPv4 and TCP headers are parsed on the fly. One byte is taken every
// cycle unless the input stalls: each byte is held in an input register, goes
// through a single stage of compare and counter logic, and the last byte of a
// frame loads the verdict register as it leaves the input register.
// Intermediate bytes give no verdict. Input stalls only while a last byte waits
// behind an untaken verdict. min_payload_bytes is written through cfg_write_enable
// and cfg_write_data and resets to 7; the user is to write it only while the
// block is idle, which the block itself does not enforce.
module http_response_packet_filter
    import hrpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_enable,
    input  logic [15:0] cfg_write_data,
    input  logic        frame_valid,
    output logic        frame_stall,
    input  logic [7:0]  frame_byte,
    input  logic        last_byte,
    output logic        verdict_valid,
    input  logic        verdict_stall,
    output logic        drop,
    output logic [2:0]  reason
);

    logic [15:0] min_payload_bytes_reg;
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        drop_reg;
    reason_t     reason_reg;
    logic        advance;
    logic        in_take;
    step_t       step;
    verdict_t    verdict;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_payload_bytes_reg <= MIN_PAYLOAD_RESET;
        end
        else if (cfg_write_enable)
        begin
            min_payload_bytes_reg <= cfg_write_data;
        end
    end

    // a last byte needs a free verdict slot, other bytes always move on
    always_comb
    begin
        advance        = in_valid_reg && (!in_last_reg || !out_valid_reg || !verdict_stall);
        frame_stall    = in_valid_reg && !advance;
        in_take        = frame_valid && !frame_stall;
        in_valid_next  = in_take || (in_valid_reg && !advance);
        out_valid_next = (advance && in_last_reg) || (out_valid_reg && verdict_stall);
        step.advance   = advance;
        step.data      = in_byte_reg;
        step.last      = in_last_reg;
    end

    hrpf_parser u_parser (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (step),
        .min_payload_bytes (min_payload_bytes_reg),
        .verdict           (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= frame_byte;
            in_last_reg <= last_byte;
        end
        if (advance && in_last_reg)
        begin
            drop_reg   <= verdict.drop;
            reason_reg <= verdict.reason;
        end
    end

    assign verdict_valid = out_valid_reg;
    assign drop          = drop_reg;
    assign reason        = reason_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid |-> (drop == (reason == REASON_HTTP || reason == REASON_BAD_IP
                                    || reason == REASON_BAD_TCP)))
        else $error("drop flag disagrees with reason");

    assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid |-> (reason == REASON_NOT_IP || reason == REASON_NOT_TCP
                           || reason == REASON_OTHER || reason == REASON_HTTP
                           || reason == REASON_BAD_IP || reason == REASON_BAD_TCP))
        else $error("reason code out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && in_last_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("last byte with free slot gave no verdict");

    assert property (@(posedge clk) disable iff (!rst_n)
        frame_stall |=> (in_valid_reg && in_last_reg))
        else $error("stalled input byte lost");
`endif

endmodule

### dv/http_response_packet_filter_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the http response packet filter
module http_response_packet_filter_tb;

    import hrpf_pkg::*;

    localparam logic [15:0] TYPE_IPV6 = 16'h86DD;
    localparam logic [7:0]  PROTO_UDP = 8'd17;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } link_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_enable = 1'b0;
    logic [15:0] cfg_write_data = 16'd0;
    logic        frame_valid = 1'b0;
    logic        frame_stall;
    logic [7:0]  frame_byte = 8'd0;
    logic        last_byte = 1'b0;
    logic        verdict_valid;
    logic        verdict_stall = 1'b0;
    logic        drop;
    logic [2:0]  reason;

    link_byte_t  pending_bytes[$];
    verdict_t    expected_verdicts[$];
    logic [7:0]  frame_buf[$];
    int          queued_bytes = 0;
    int          mismatch_count = 0;
    int          sender_idle_pct = 0;
    int          stall_pct = 0;
    bit          frame_sent = 1'b0;

    // predictor state
    logic [15:0] min_payload_cfg = MIN_PAYLOAD_RESET;
    logic [15:0] byte_count;
    logic [15:0] ether_type_seen;
    logic [1:0]  tags_seen;
    int          ip_offset;
    logic [3:0]  ihl_seen;
    logic [7:0]  proto_seen;
    logic [15:0] total_len_seen;
    logic [3:0]  tcp_words_seen;
    logic [31:0] payload_head;

    http_response_packet_filter DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .frame_valid      (frame_valid),
        .frame_stall      (frame_stall),
        .frame_byte       (frame_byte),
        .last_byte        (last_byte),
        .verdict_valid    (verdict_valid),
        .verdict_stall    (verdict_stall),
        .drop             (drop),
        .reason           (reason)
    );

    always #10 clk = ~clk;

    task automatic clear_frame_state();
        byte_count      = 16'd0;
        ether_type_seen = 16'd0;
        tags_seen       = 2'd0;
        ip_offset       = int'(L2_LEN);
        ihl_seen        = 4'd0;
        proto_seen      = 8'd0;
        total_len_seen  = 16'd0;
        tcp_words_seen  = 4'd0;
        payload_head    = 32'd0;
    endtask

    task automatic predict_frame_byte(input logic [7:0] b, input logic last);
        int       idx;
        int       r;
        int       t;
        int       p;
        int       frame_len;
        int       payload_len;
        verdict_t v;
        idx = int'(byte_count);
        if (idx == ip_offset - 2 || idx == ip_offset - 1)
            ether_type_seen = {ether_type_seen[7:0], b};
        if (idx == ip_offset - 1)
        begin
            if ((ether_type_seen == TYPE_QTAG || ether_type_seen == TYPE_ADTAG)
                && tags_seen < MAX_TAGS)
            begin
                tags_seen = tags_seen + 2'd1;
                ip_offset = ip_offset + int'(TAG_LEN);
            end
        end
        else if (idx >= ip_offset)
        begin
            r = idx - ip_offset;
            if (r == 0)
                ihl_seen = b[3:0];
            else if (r == 2 || r == 3)
                total_len_seen = {total_len_seen[7:0], b};
            else if (r == 9)
                proto_seen = b;
            if (ihl_seen >= MIN_HDR_WORDS && r >= int'(ihl_seen) * 4)
            begin
                t = r - int'(ihl_seen) * 4;
                if (t == int'(TCP_OFFSET_BYTE))
                    tcp_words_seen = b[7:4];
                if (tcp_words_seen >= MIN_HDR_WORDS && t >= int'(tcp_words_seen) * 4)
                begin
                    p = t - int'(tcp_words_seen) * 4;
                    if (p < 4)
                        payload_head = payload_head | (32'(b) << (24 - 8 * p));
                end
            end
        end
        if (byte_count != INDEX_MAX)
            byte_count = byte_count + 16'd1;
        if (last)
        begin
            frame_len = idx + 1;
            v.drop = 1'b0;
            if (frame_len < ip_offset || ether_type_seen != TYPE_IPV4)
                v.reason = REASON_NOT_IP;
            else if (frame_len < ip_offset + int'(MIN_HDR_BYTES))
            begin
                v.drop   = 1'b1;
                v.reason = REASON_BAD_IP;
            end
            else if (proto_seen != PROTO_TCP)
                v.reason = REASON_NOT_TCP;
            else if (ihl_seen < MIN_HDR_WORDS)
            begin
                v.drop   = 1'b1;
                v.reason = REASON_BAD_IP;
            end
            else if (frame_len < ip_offset + int'(ihl_seen) * 4 + int'(MIN_HDR_BYTES)
                     || tcp_words_seen < MIN_HDR_WORDS)
            begin
                v.drop   = 1'b1;
                v.reason = REASON_BAD_TCP;
            end
            else
            begin
                payload_len = int'(total_len_seen) - int'(ihl_seen) * 4
                            - int'(tcp_words_seen) * 4;
                v.reason = REASON_OTHER;
                if (payload_len >= 0 && payload_len >= int'(min_payload_cfg)
                    && payload_head == HTTP_WORD)
                begin
                    v.drop   = 1'b1;
                    v.reason = REASON_HTTP;
                end
            end
            expected_verdicts.push_back(v);
            clear_frame_state();
        end
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("ERROR at %0t ns: %s is %0d, expected %0d", $time, field, got, want);
        mismatch_count++;
    endtask

    function automatic logic [7:0] rand_byte();
        logic [31:0] rnd;
        rnd = $urandom;
        return rnd[7:0];
    endfunction

    task automatic commit_frame();
        link_byte_t lb;
        for (int i = 0; i < frame_buf.size(); i++)
        begin
            lb.data = frame_buf[i];
            lb.last = (i == frame_buf.size() - 1);
            pending_bytes.push_back(lb);
        end
        queued_bytes += frame_buf.size();
        frame_buf.delete();
    endtask

    // total_len below zero means consistent with the bytes sent, cut below one means no cut
    task automatic queue_frame(input int tags, input logic [15:0] etype, input logic [3:0] ihl,
                               input logic [7:0] proto, input logic [3:0] doff,
                               input int total_len, input int pay_len, input bit http,
                               input int cut);
        int          ip_len;
        int          tcp_len;
        logic [15:0] tlen;
        logic [7:0]  rb;
        for (int i = 0; i < 12; i++)
            frame_buf.push_back(rand_byte());
        for (int i = 0; i < tags; i++)
        begin
            rb = rand_byte();
            frame_buf.push_back(rb[0] ? TYPE_QTAG[15:8] : TYPE_ADTAG[15:8]);
            frame_buf.push_back(rb[0] ? TYPE_QTAG[7:0] : TYPE_ADTAG[7:0]);
            frame_buf.push_back(rand_byte());
            frame_buf.push_back(rand_byte());
        end
        frame_buf.push_back(etype[15:8]);
        frame_buf.push_back(etype[7:0]);
        ip_len  = (ihl < MIN_HDR_WORDS) ? int'(MIN_HDR_BYTES) : int'(ihl) * 4;
        tcp_len = (doff < MIN_HDR_WORDS) ? int'(MIN_HDR_BYTES) : int'(doff) * 4;
        if (total_len < 0)
            tlen = 16'(int'(ihl) * 4 + int'(doff) * 4 + pay_len);
        else
            tlen = 16'(total_len);
        for (int i = 0; i < ip_len; i++)
        begin
            if (i == 0)
                frame_buf.push_back({4'h4, ihl});
            else if (i == 2)
                frame_buf.push_back(tlen[15:8]);
            else if (i == 3)
                frame_buf.push_back(tlen[7:0]);
            else if (i == 9)
                frame_buf.push_back(proto);
            else
                frame_buf.push_back(rand_byte());
        end
        for (int i = 0; i < tcp_len; i++)
        begin
            rb = rand_byte();
            if (i == int'(TCP_OFFSET_BYTE))
                frame_buf.push_back({doff, rb[3:0]});
            else
                frame_buf.push_back(rb);
        end
        for (int i = 0; i < pay_len; i++)
        begin
            if (http && i < 4)
                frame_buf.push_back(HTTP_WORD[31 - 8 * i -: 8]);
            else
                frame_buf.push_back(rand_byte());
        end
        while (cut > 0 && frame_buf.size() > cut)
            void'(frame_buf.pop_back());
        commit_frame();
    endtask

    task automatic queue_random_frame();
        int          tags;
        logic [15:0] etype;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [3:0]  doff;
        int          total_len;
        int          pay_len;
        int          cut;
        int          sel;
        sel = $urandom_range(99);
        if (sel < 25)
        begin
            // noise frame
            pay_len = $urandom_range(1, 40);
            for (int i = 0; i < pay_len; i++)
                frame_buf.push_back(rand_byte());
            commit_frame();
        end
        else
        begin
            sel  = $urandom_range(99);
            tags = (sel < 50) ? 0 : (sel < 72) ? 1 : (sel < 95) ? 2 : 3;
            etype = ($urandom_range(99) < 90) ? TYPE_IPV4 : 16'($urandom);
            sel = $urandom_range(99);
            ihl = (sel < 80) ? 4'd5 : (sel < 95) ? 4'($urandom_range(6, 15))
                                                 : 4'($urandom_range(0, 4));
            proto = ($urandom_range(99) < 90) ? PROTO_TCP : rand_byte();
            sel = $urandom_range(99);
            doff = (sel < 75) ? 4'd5 : (sel < 95) ? 4'($urandom_range(6, 15))
                                                  : 4'($urandom_range(0, 4));
            pay_len = $urandom_range(0, 24);
            sel = $urandom_range(99);
            if (sel < 60)
                total_len = -1;
            else if (sel < 88)
                total_len = (int'(ihl) * 4 + int'(doff) * 4 + int'(min_payload_cfg)
                             + int'($urandom_range(4)) - 2) & 32'hFFFF;
            else
                total_len = int'($urandom_range(16'hFFFF));
            cut = ($urandom_range(99) < 85) ? -1 : int'($urandom_range(1, 80));
            queue_frame(tags, etype, ihl, proto, doff, total_len, pay_len,
                        $urandom_range(99) < 65, cut);
        end
    endtask

    task automatic drain_all();
        while (pending_bytes.size() != 0 || frame_valid || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_min_payload(input logic [15:0] value);
        @(negedge clk);
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= value;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
        min_payload_cfg = value;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                sender_idle_pct = 0;
                stall_pct       = 0;
            end
            1:
            begin
                sender_idle_pct = 78;
                stall_pct       = 0;
            end
            2:
            begin
                sender_idle_pct = 0;
                stall_pct       = 78;
            end
            default:
            begin
                sender_idle_pct = 25;
                stall_pct       = 25;
            end
        endcase
    endtask

    // driver
    always @(negedge clk)
    begin : drive_frames
        link_byte_t next_byte;
        if (!rst_n)
        begin
            frame_valid   <= 1'b0;
            verdict_stall <= 1'b0;
        end
        else
        begin
            if (!frame_valid || frame_sent)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    next_byte = pending_bytes.pop_front();
                    frame_valid <= 1'b1;
                    frame_byte  <= next_byte.data;
                    last_byte   <= next_byte.last;
                end
                else
                    frame_valid <= 1'b0;
            end
            frame_sent = 1'b0;
            verdict_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin : watch_transfers
        verdict_t want;
        if (rst_n)
        begin
            if (verdict_valid && !verdict_stall)
            begin
                if (expected_verdicts.size() == 0)
                    report_mismatch("verdict with no frame outstanding, reason", reason, 0);
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (drop !== want.drop)
                        report_mismatch("drop", drop, want.drop);
                    if (reason !== want.reason)
                        report_mismatch("reason", reason, want.reason);
                end
            end
            if (frame_valid && !frame_stall)
            begin
                frame_sent = 1'b1;
                predict_frame_byte(frame_byte, last_byte);
            end
        end
    end

    initial
    begin
        logic [15:0] cfg_values[5];
        int          target;
        clear_frame_state();
        cfg_values = '{MIN_PAYLOAD_RESET, 16'd0, 16'hFFFF, 16'd4,
                       16'($urandom_range(5, 40))};
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // directed frames
        frame_buf.push_back(8'hFF);
        commit_frame();
        queue_frame(0, TYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, -1, 8, 1, 13);
        queue_frame(0, TYPE_IPV6, 4'd5, PROTO_TCP, 4'd5, -1, 8, 1, -1);
        queue_frame(1, TYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, -1, 8, 1, 15);
        queue_frame(3, TYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, -1, 8, 1, -1);
        queue_frame(2, TYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, -1, 8, 1, -1);
        queue_frame(0, TYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, -1, 8, 1, 33);
        queue_frame(0, TYPE_IPV4, 4'd4, PROTO_TCP, 4'd5, -1, 8, 1, -1);
        queue_frame(0, TYPE_IPV4, 4'd0, PROTO_UDP, 4'd5, -1, 8, 1, -1);
        queue_frame(0, TYPE_IPV4, 4'd5, 8'hFF, 4'd5, -1, 8, 1, -1);
        queue_frame(0, TYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, -1, 8, 1, 53);
        queue_frame(0, TYPE_IPV4, 4'd5, PROTO_TCP, 4'd4, -1, 8, 1, -1);
        queue_frame(0, TYPE_IPV4, 4'd5, PROTO_TCP, 4'd0, -1, 8, 1, -1);
        queue_frame(0, TYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, -1, 7, 1, -1);
        queue_frame(0, TYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, -1, 6, 1, -1);
        // negative payload length, then payload cut short after two bytes
        queue_frame(0, TYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 10, 8, 1, -1);
        queue_frame(0, TYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 60, 2, 1, -1);
        queue_frame(2, TYPE_IPV4, 4'd15, PROTO_TCP, 4'd15, 16'hFFFF, 12, 1, -1);
        for (int i = 0; i < 30; i++)
            frame_buf.push_back(8'h00);
        commit_frame();
        for (int i = 0; i < 30; i++)
            frame_buf.push_back(8'hFF);
        commit_frame();
        drain_all();

        // random frames across register settings and idling modes
        for (int c = 0; c < 5; c++)
        begin
            if (c > 0)
                write_min_payload(cfg_values[c]);
            for (int m = 0; m < 2; m++)
            begin
                set_idling((c + m) % 4);
                target = queued_bytes + 20;
                while (queued_bytes < target)
                    queue_random_frame();
                drain_all();
            end
        end

        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && expected_verdicts.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
src/hrpf_pkg.sv
src/hrpf_parser.sv
src/http_response_packet_filter.sv
dv/http_response_packet_filter_tb.sv
